// File: sv/ows_pkg.sv
// Package for the 1-Wire search-ROM decision engine.
// Holds the word types, the action and status codes and the fixed constants.
// No dependencies; the design files refer to it by scoped names, the test files import it.
`default_nettype none

package ows_pkg;

    localparam int ROM_BITS = 64;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 6;
    localparam int FD_W     = 4;
    localparam int CRC_W    = 8;

    localparam logic [POS_W-1:0] POS_FIRST    = 7'd1;
    localparam logic [POS_W-1:0] POS_LAST     = 7'd64;
    localparam logic [POS_W-1:0] POS_DONE     = 7'd65;
    localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;
    localparam logic [CRC_W-1:0] CRC_POLY     = 8'h8C;
    localparam logic [7:0]       FAMILY_ZERO  = 8'h00;

    typedef enum logic [1:0] {
        ACT_FRESH    = 2'd0,
        ACT_CONTINUE = 2'd1,
        ACT_BIT_PAIR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_PROCEED = 3'd0,
        ST_WRITE   = 3'd1,
        ST_FOUND   = 3'd2,
        ST_FAILED  = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } in_word_t;

    typedef struct packed {
        status_t               status;
        logic                  direction;
        logic [ROM_BITS-1:0]   rom_code;
        logic                  last_device;
        logic [FD_W-1:0]       family_discrepancy_out;
    } out_word_t;

endpackage

`default_nettype wire

// File: sv/ows_if.sv
// Valid/ready channel interfaces for the search-ROM engine: request and result.
// Depends on ows_pkg for the payload widths.
`default_nettype none

interface ows_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;

    modport source (output valid, output action, output presence, output id_bit,
                    output complement_bit, input ready);
    modport sink   (input valid, input action, input presence, input id_bit,
                    input complement_bit, output ready);
endinterface

interface ows_out_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     status;
    logic                           direction;
    logic [ows_pkg::ROM_BITS-1:0]   rom_code;
    logic                           last_device;
    logic [ows_pkg::FD_W-1:0]       family_discrepancy_out;

    modport source (output valid, output status, output direction, output rom_code,
                    output last_device, output family_discrepancy_out, input ready);
    modport sink   (input valid, input status, input direction, input rom_code,
                    input last_device, input family_discrepancy_out, output ready);
endinterface

`default_nettype wire

// File: sv/ows_in_reg.sv
// Input register of the search-ROM engine: captures one request word.
// Depends on ows_pkg.
`default_nettype none

module ows_in_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ows_pkg::in_word_t in_word,
    input  wire logic              out_free,
    output logic                   word_valid,
    output ows_pkg::in_word_t      word
);

    logic              valid_reg;
    logic              valid_next;
    ows_pkg::in_word_t word_reg;
    logic              advance;

    // The held word moves on whenever the output register can take its result.
    assign advance    = valid_reg && out_free;
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// File: sv/ows_engine.sv
// Search-ROM decision logic and search state: one request word per cycle while go is high.
// Depends on ows_pkg.
`default_nettype none

module ows_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire ows_pkg::in_word_t  word,
    output ows_pkg::out_word_t      result
);

    logic [ows_pkg::ROM_BITS-1:0] rom_bits_reg, rom_bits_next;
    logic [ows_pkg::POS_W-1:0]    last_discrepancy_reg, last_discrepancy_next;
    logic [ows_pkg::FD_W-1:0]     family_discrepancy_reg, family_discrepancy_next;
    logic                         last_device_seen_reg, last_device_seen_next;
    logic [ows_pkg::POS_W-1:0]    bit_position_reg, bit_position_next;
    logic [ows_pkg::POS_W-1:0]    last_zero_position_reg, last_zero_position_next;
    logic [ows_pkg::CRC_W-1:0]    running_crc_reg, running_crc_next;
    logic                         search_active_reg, search_active_next;

    logic [ows_pkg::POS_W-1:0]    pos;
    logic [ows_pkg::IDX_W-1:0]    idx;
    logic                         dir;
    logic                         feedback;
    logic [ows_pkg::CRC_W-1:0]    crc_shifted;
    logic [ows_pkg::POS_W-1:0]    zero_pos_upd;
    logic [ows_pkg::ROM_BITS-1:0] rom_upd;
    logic                         seen_eff;
    ows_pkg::status_t             status;
    logic                         out_dir;

    // Clamp the position into the ROM range before it is used as an index.
    always_comb
    begin
        if (bit_position_reg < ows_pkg::POS_FIRST)
        begin
            pos = ows_pkg::POS_FIRST;
        end
        else if (bit_position_reg > ows_pkg::POS_LAST)
        begin
            pos = ows_pkg::POS_LAST;
        end
        else
        begin
            pos = bit_position_reg;
        end
    end

    assign idx = ows_pkg::IDX_W'(pos - ows_pkg::POS_FIRST);

    // Direction: a disagreement dictates the bit; a discrepancy follows the
    // previous pass below the last discrepancy and takes one at it.
    always_comb
    begin
        if (word.id_bit != word.complement_bit)
        begin
            dir = word.id_bit;
        end
        else if (pos < last_discrepancy_reg)
        begin
            dir = rom_bits_reg[idx];
        end
        else
        begin
            dir = (pos == last_discrepancy_reg);
        end
    end

    always_comb
    begin
        zero_pos_upd = last_zero_position_reg;
        if ((word.id_bit == word.complement_bit) && !dir)
        begin
            zero_pos_upd = pos;
        end
        rom_upd      = rom_bits_reg;
        rom_upd[idx] = dir;
    end

    assign feedback    = running_crc_reg[0] ^ dir;
    assign crc_shifted = {1'b0, running_crc_reg[ows_pkg::CRC_W-1:1]}
                         ^ (feedback ? ows_pkg::CRC_POLY : '0);
    assign seen_eff    = (word.action == ows_pkg::ACT_FRESH) ? 1'b0 : last_device_seen_reg;

    always_comb
    begin
        rom_bits_next           = rom_bits_reg;
        last_discrepancy_next   = last_discrepancy_reg;
        family_discrepancy_next = family_discrepancy_reg;
        last_device_seen_next   = last_device_seen_reg;
        bit_position_next       = bit_position_reg;
        last_zero_position_next = last_zero_position_reg;
        running_crc_next        = running_crc_reg;
        search_active_next      = search_active_reg;
        status                  = ows_pkg::ST_IGNORED;
        out_dir                 = 1'b0;

        priority if ((word.action == ows_pkg::ACT_FRESH) ||
                     (word.action == ows_pkg::ACT_CONTINUE))
        begin
            if (word.action == ows_pkg::ACT_FRESH)
            begin
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                last_device_seen_next   = 1'b0;
            end
            running_crc_next   = '0;
            search_active_next = 1'b0;
            if (seen_eff || !word.presence)
            begin
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                last_device_seen_next   = 1'b0;
                status                  = ows_pkg::ST_FAILED;
            end
            else
            begin
                search_active_next      = 1'b1;
                bit_position_next       = ows_pkg::POS_FIRST;
                last_zero_position_next = '0;
                status                  = ows_pkg::ST_PROCEED;
            end
        end
        else if ((word.action == ows_pkg::ACT_BIT_PAIR) && search_active_reg)
        begin
            if (word.id_bit && word.complement_bit)
            begin
                last_discrepancy_next   = '0;
                family_discrepancy_next = '0;
                last_device_seen_next   = 1'b0;
                search_active_next      = 1'b0;
                status                  = ows_pkg::ST_FAILED;
            end
            else
            begin
                out_dir                 = dir;
                rom_bits_next           = rom_upd;
                running_crc_next        = crc_shifted;
                last_zero_position_next = zero_pos_upd;
                if ((word.id_bit == word.complement_bit) && !dir &&
                    (pos < ows_pkg::FAMILY_LIMIT))
                begin
                    family_discrepancy_next = ows_pkg::FD_W'(pos);
                end
                if (pos < ows_pkg::POS_LAST)
                begin
                    bit_position_next = pos + ows_pkg::POS_FIRST;
                    status            = ows_pkg::ST_WRITE;
                end
                else
                begin
                    search_active_next = 1'b0;
                    bit_position_next  = ows_pkg::POS_DONE;
                    if (crc_shifted != '0)
                    begin
                        last_discrepancy_next   = '0;
                        family_discrepancy_next = '0;
                        last_device_seen_next   = 1'b0;
                        status                  = ows_pkg::ST_FAILED;
                    end
                    else
                    begin
                        last_discrepancy_next = zero_pos_upd;
                        if (zero_pos_upd == '0)
                        begin
                            last_device_seen_next = 1'b1;
                        end
                        status = ows_pkg::ST_FOUND;
                        // A zero family byte cannot belong to a real device.
                        if (rom_upd[7:0] == ows_pkg::FAMILY_ZERO)
                        begin
                            last_discrepancy_next   = '0;
                            family_discrepancy_next = '0;
                            last_device_seen_next   = 1'b0;
                            status                  = ows_pkg::ST_FAILED;
                        end
                    end
                end
            end
        end
        else
        begin
            status = ows_pkg::ST_IGNORED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bits_reg           <= '0;
            last_discrepancy_reg   <= '0;
            family_discrepancy_reg <= '0;
            last_device_seen_reg   <= 1'b0;
            bit_position_reg       <= ows_pkg::POS_FIRST;
            last_zero_position_reg <= '0;
            running_crc_reg        <= '0;
            search_active_reg      <= 1'b0;
        end
        else if (go)
        begin
            rom_bits_reg           <= rom_bits_next;
            last_discrepancy_reg   <= last_discrepancy_next;
            family_discrepancy_reg <= family_discrepancy_next;
            last_device_seen_reg   <= last_device_seen_next;
            bit_position_reg       <= bit_position_next;
            last_zero_position_reg <= last_zero_position_next;
            running_crc_reg        <= running_crc_next;
            search_active_reg      <= search_active_next;
        end
    end

    assign result.status                 = status;
    assign result.direction              = out_dir;
    assign result.rom_code               = rom_bits_next;
    assign result.last_device            = last_device_seen_next;
    assign result.family_discrepancy_out = family_discrepancy_next;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_position_reg >= ows_pkg::POS_FIRST) && (bit_position_reg <= ows_pkg::POS_DONE))
        else $error("bit position left its range");

    a_active_pos: assert property (@(posedge clk) disable iff (!rst_n)
        search_active_reg |-> (bit_position_reg <= ows_pkg::POS_LAST))
        else $error("search running past the last ROM bit");

    a_last_device: assert property (@(posedge clk) disable iff (!rst_n)
        last_device_seen_reg |-> (last_discrepancy_reg == '0) && !search_active_reg)
        else $error("last device flagged with a pending discrepancy");

    a_family_range: assert property (@(posedge clk) disable iff (!rst_n)
        family_discrepancy_reg < ows_pkg::FD_W'(ows_pkg::FAMILY_LIMIT))
        else $error("family discrepancy outside the family byte");

    a_idle_pair: assert property (@(posedge clk) disable iff (!rst_n)
        go && (word.action == ows_pkg::ACT_BIT_PAIR) && !search_active_reg
        |=> $stable(rom_bits_reg) && $stable(bit_position_reg))
        else $error("bit pair outside a search changed the state");

endmodule

`default_nettype wire

// File: sv/ows_out_reg.sv
// Output register of the search-ROM engine: holds one result word until taken.
// Depends on ows_pkg.
`default_nettype none

module ows_out_reg
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire ows_pkg::out_word_t word,
    output logic                    out_free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ows_pkg::out_word_t      out_word
);

    logic               valid_reg;
    logic               valid_next;
    ows_pkg::out_word_t word_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// File: sv/onewire_rom_search_top.sv
// Top level of the 1-Wire search-ROM decision engine.
// Depends on ows_pkg, ows_if, ows_in_reg, ows_engine and ows_out_reg.
//
// Usage: the bus controller sends request words on the request channel. A
// begin word (fresh or continuing search) carries the presence result of the
// bus reset; each bit-pair word carries the id and complement bits of one ROM
// position. Every request word gives exactly one result word on the response
// channel: a status, the direction bit to write, and the ROM code, last-device
// flag and family discrepancy as they stand after that word.
// Flow: an accepted word waits in the input register and its result is loaded
// into the output register and offered from there. One word per cycle is
// sustained while the receiver keeps up; the decision is a single pass from
// the input register through the engine logic into the output register.
// Reset clears the search state (no search running, empty ROM code, position
// one) and empties both registers. When the receiver stalls, the result word
// holds, the input register keeps one further word, and request ready drops
// only when both are occupied.
`default_nettype none

module onewire_rom_search_top
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ows_in_if.sink      request,
    ows_out_if.source   response
);

    ows_pkg::in_word_t  in_word;
    ows_pkg::in_word_t  held_word;
    ows_pkg::out_word_t result;
    ows_pkg::out_word_t out_word;
    logic               word_valid;
    logic               out_free;
    logic               go;

    assign in_word.action         = request.action;
    assign in_word.presence       = request.presence;
    assign in_word.id_bit         = request.id_bit;
    assign in_word.complement_bit = request.complement_bit;

    ows_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (request.valid),
        .in_ready   (request.ready),
        .in_word    (in_word),
        .out_free   (out_free),
        .word_valid (word_valid),
        .word       (held_word)
    );

    assign go = word_valid && out_free;

    ows_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .word   (held_word),
        .result (result)
    );

    ows_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .word      (result),
        .out_free  (out_free),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .out_word  (out_word)
    );

    assign response.status                 = out_word.status;
    assign response.direction              = out_word.direction;
    assign response.rom_code               = out_word.rom_code;
    assign response.last_device            = out_word.last_device;
    assign response.family_discrepancy_out = out_word.family_discrepancy_out;

endmodule

`default_nettype wire

// File: test/ows_search_checker.sv
// Checker for the 1-Wire search-ROM engine. It watches both channels, predicts
// every result word from the request words and compares them field by field.
// Depends on ows_pkg for the status codes, the word layout and the constants.
module ows_search_checker
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    input  wire logic                       req_ready,
    input  wire logic [1:0]                 req_action,
    input  wire logic                       req_presence,
    input  wire logic                       req_id_bit,
    input  wire logic                       req_complement_bit,
    input  wire logic                       resp_valid,
    input  wire logic                       resp_ready,
    input  wire logic [2:0]                 resp_status,
    input  wire logic                       resp_direction,
    input  wire logic [ows_pkg::ROM_BITS-1:0] resp_rom_code,
    input  wire logic                       resp_last_device,
    input  wire logic [ows_pkg::FD_W-1:0]   resp_family_discrepancy_out,
    output int                              mismatches,
    output int                              outstanding,
    output logic                            decided_direction,
    output ows_pkg::status_t                decided_status
);
    timeunit 1ns;
    timeprecision 1ps;

    import ows_pkg::*;

    // Search memory as the engine should hold it.
    logic [ROM_BITS-1:0] found_rom;
    logic [POS_W-1:0]    resume_point;
    logic [FD_W-1:0]     family_mark;
    logic                last_found;
    logic [POS_W-1:0]    cursor;
    logic [POS_W-1:0]    zero_taken;
    logic [CRC_W-1:0]    crc_acc;
    logic                in_search;

    out_word_t awaited_words[$];

    task automatic forget_search();
        resume_point = '0;
        family_mark  = '0;
        last_found   = 1'b0;
        in_search    = 1'b0;
    endtask

    task automatic predict_word(input logic [1:0] act, input logic pres, input logic idb,
                                input logic cmp, output out_word_t w);
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] idx;
        logic             dir;
        logic             fb;
        status_t          st;
        dir = 1'b0;
        st  = ST_IGNORED;
        if (act == ACT_FRESH || act == ACT_CONTINUE)
        begin
            if (act == ACT_FRESH)
                forget_search();
            crc_acc   = '0;
            in_search = 1'b0;
            if (last_found || !pres)
            begin
                forget_search();
                st = ST_FAILED;
            end
            else
            begin
                in_search  = 1'b1;
                cursor     = POS_FIRST;
                zero_taken = '0;
                st         = ST_PROCEED;
            end
        end
        else if (act == ACT_BIT_PAIR && in_search)
        begin
            if (idb && cmp)
            begin
                forget_search();
                st = ST_FAILED;
            end
            else
            begin
                pos = cursor;
                if (pos < POS_FIRST)
                    pos = POS_FIRST;
                if (pos > POS_LAST)
                    pos = POS_LAST;
                idx = pos[IDX_W-1:0] - 1'b1;
                if (idb != cmp)
                    dir = idb;
                else
                begin
                    // A discrepancy: follow the earlier path below the resume point,
                    // take one at it and zero beyond it.
                    if (pos < resume_point)
                        dir = found_rom[idx];
                    else
                        dir = (pos == resume_point);
                    if (!dir)
                    begin
                        zero_taken = pos;
                        if (pos < FAMILY_LIMIT)
                            family_mark = pos[FD_W-1:0];
                    end
                end
                found_rom[idx] = dir;
                fb      = crc_acc[0] ^ dir;
                crc_acc = crc_acc >> 1;
                if (fb)
                    crc_acc = crc_acc ^ CRC_POLY;
                if (pos < POS_LAST)
                begin
                    cursor = pos + 1'b1;
                    st     = ST_WRITE;
                end
                else
                begin
                    in_search = 1'b0;
                    cursor    = POS_DONE;
                    if (crc_acc != '0)
                    begin
                        forget_search();
                        st = ST_FAILED;
                    end
                    else
                    begin
                        resume_point = zero_taken;
                        if (resume_point == '0)
                            last_found = 1'b1;
                        if (found_rom[7:0] == FAMILY_ZERO)
                        begin
                            forget_search();
                            st = ST_FAILED;
                        end
                        else
                            st = ST_FOUND;
                    end
                end
            end
        end
        w.status                 = st;
        w.direction              = dir;
        w.rom_code               = found_rom;
        w.last_device            = last_found;
        w.family_discrepancy_out = family_mark;
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t w;
        if (!rst_n)
        begin
            found_rom    = '0;
            resume_point = '0;
            family_mark  = '0;
            last_found   = 1'b0;
            cursor       = POS_FIRST;
            zero_taken   = '0;
            crc_acc      = '0;
            in_search    = 1'b0;
            awaited_words.delete();
            mismatches        = 0;
            outstanding       = 0;
            decided_direction = 1'b0;
            decided_status    = ST_IGNORED;
        end
        else
        begin
            if (resp_valid && resp_ready)
            begin
                if (awaited_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with none expected, actual status %0d",
                             $time, resp_status);
                end
                else
                begin
                    w = awaited_words.pop_front();
                    compare_field("status", 64'(w.status), 64'(resp_status));
                    compare_field("direction", 64'(w.direction), 64'(resp_direction));
                    compare_field("rom_code", w.rom_code, resp_rom_code);
                    compare_field("last_device", 64'(w.last_device), 64'(resp_last_device));
                    compare_field("family_discrepancy_out", 64'(w.family_discrepancy_out),
                                  64'(resp_family_discrepancy_out));
                end
            end
            if (req_valid && req_ready)
            begin
                predict_word(req_action, req_presence, req_id_bit, req_complement_bit, w);
                awaited_words.push_back(w);
                decided_direction = w.direction;
                decided_status    = w.status;
            end
            outstanding = awaited_words.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top for the 1-Wire search-ROM engine: clock, reset, a modelled bus
// of devices that answers each bit position, and random stalls on both channels.
// Depends on ows_pkg, ows_if, onewire_rom_search_top and ows_search_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ows_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WORD_TARGET = 1600;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int MAX_DEVICES = 8;

    logic clk;
    logic rst_n;

    ows_in_if  request ();
    ows_out_if response ();

    int      mismatches;
    int      outstanding;
    logic    decided_direction;
    status_t decided_status;

    int   words_sent;
    logic sender_burst;
    logic long_hold_done;
    int   idle_cycles;

    // The devices on the modelled bus and which of them still follow the path.
    logic [ROM_BITS-1:0] bus_rom [MAX_DEVICES];
    int                  bus_size;
    logic [MAX_DEVICES-1:0] on_path;

    onewire_rom_search_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    ows_search_checker checker_inst
    (
        .clk                         (clk),
        .rst_n                       (rst_n),
        .req_valid                   (request.valid),
        .req_ready                   (request.ready),
        .req_action                  (request.action),
        .req_presence                (request.presence),
        .req_id_bit                  (request.id_bit),
        .req_complement_bit          (request.complement_bit),
        .resp_valid                  (response.valid),
        .resp_ready                  (response.ready),
        .resp_status                 (response.status),
        .resp_direction              (response.direction),
        .resp_rom_code               (response.rom_code),
        .resp_last_device            (response.last_device),
        .resp_family_discrepancy_out (response.family_discrepancy_out),
        .mismatches                  (mismatches),
        .outstanding                 (outstanding),
        .decided_direction           (decided_direction),
        .decided_status              (decided_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] dallas_crc8(input logic [55:0] body);
        logic [7:0] c;
        logic       fb;
        c = 8'h00;
        for (int i = 0; i < 56; i++)
        begin
            fb = c[0] ^ body[i];
            c  = c >> 1;
            if (fb)
                c = c ^ 8'h8C;
        end
        return c;
    endfunction

    // Lowers valid at the next falling edge and, outside a burst, idles for a random stretch.
    task automatic next_slot();
        int gap;
        @(negedge clk);
        request.valid = 1'b0;
        {request.action, request.presence, request.id_bit, request.complement_bit} =
            5'($urandom);
        gap = sender_burst ? 0 : gap_length();
        repeat (gap)
        begin
            @(negedge clk);
            {request.action, request.presence, request.id_bit, request.complement_bit} =
                5'($urandom);
        end
    endtask

    task automatic offer_word(input logic [1:0] act, input logic pres, input logic idb,
                              input logic cmp);
        request.valid          = 1'b1;
        request.action         = act;
        request.presence       = pres;
        request.id_bit         = idb;
        request.complement_bit = cmp;
        do
            @(posedge clk);
        while (!request.ready);
        words_sent++;
    endtask

    task automatic send_word(input logic [1:0] act, input logic pres, input logic idb,
                             input logic cmp);
        next_slot();
        offer_word(act, pres, idb, cmp);
    endtask

    task automatic build_bus();
        logic [55:0] body;
        logic [7:0]  fam;
        int          r;
        bus_size = ($urandom_range(0, 4) == 0) ? $urandom_range(4, MAX_DEVICES)
                                               : $urandom_range(1, 3);
        for (int k = 0; k < bus_size; k++)
        begin
            if (k > 0 && $urandom_range(0, 2) == 0)
            begin
                // A near twin of an earlier device, so that paths split late.
                body = bus_rom[$urandom_range(0, k - 1)][55:0];
                repeat ($urandom_range(1, 2))
                    body[$urandom_range(0, 55)] ^= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 3);
                fam = (r == 0) ? 8'h10 : (r == 1) ? 8'h28 : (r == 2) ? 8'h01 : 8'hFF;
                body = {24'($urandom), 24'($urandom), fam};
            end
            if ($urandom_range(0, 39) == 0)
                body[7:0] = FAMILY_ZERO;
            bus_rom[k] = {dallas_crc8(body), body};
            if ($urandom_range(0, 39) == 0)
                bus_rom[k][63:56] ^= 8'($urandom_range(1, 255));
        end
    endtask

    task automatic bus_bits(input int pos, output logic idb, output logic cmp);
        idb = 1'b1;
        cmp = 1'b1;
        for (int k = 0; k < bus_size; k++)
            if (on_path[k])
            begin
                idb &= bus_rom[k][pos];
                cmp &= ~bus_rom[k][pos];
            end
    endtask

    // Runs successive search passes over a fresh bus until the engine reports
    // that the bus is exhausted, the pass limit is met or the word target reached.
    task automatic enumerate_bus();
        logic pres;
        logic idb;
        logic cmp;
        int   cut;
        build_bus();
        for (int p = 0; p < bus_size + 3; p++)
        begin
            if (words_sent >= WORD_TARGET)
                break;
            sender_burst = ($urandom_range(0, 3) == 0);
            pres = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 9) == 0)
                send_word($urandom_range(0, 1) ? ACT_UNUSED : ACT_BIT_PAIR,
                          1'($urandom), 1'($urandom), 1'($urandom));
            send_word((p == 0) ? ACT_FRESH : ACT_CONTINUE, pres, 1'($urandom),
                      1'($urandom));
            next_slot();
            if (decided_status != ST_PROCEED)
            begin
                if (pres)
                    break;
                continue;
            end
            on_path = '1;
            cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, ROM_BITS - 1) : ROM_BITS;
            for (int pos = 0; pos < ROM_BITS; pos++)
            begin
                if (pos > 0)
                begin
                    next_slot();
                    for (int k = 0; k < bus_size; k++)
                        if (bus_rom[k][pos - 1] != decided_direction)
                            on_path[k] = 1'b0;
                    if (decided_status != ST_WRITE)
                        break;
                end
                if (pos == cut)
                    break;
                bus_bits(pos, idb, cmp);
                if ($urandom_range(0, 149) == 0)
                    {idb, cmp} = 2'($urandom);
                offer_word(ACT_BIT_PAIR, 1'($urandom), idb, cmp);
            end
        end
    endtask

    // Receiver: random stalls, free-flowing stretches and one long hold-off.
    initial
    begin : result_sink
        int run;
        int stall;
        response.ready = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && words_sent >= 600)
            begin
                long_hold_done = 1'b1;
                @(negedge clk);
                response.ready = 1'b0;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
            repeat (run)
            begin
                @(negedge clk);
                response.ready = 1'b1;
            end
            stall = gap_length();
            repeat (stall)
            begin
                @(negedge clk);
                response.ready = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request.valid && request.ready) || (response.valid && response.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic drained;
        request.valid          = 1'b0;
        request.action         = ACT_FRESH;
        request.presence       = 1'b0;
        request.id_bit         = 1'b0;
        request.complement_bit = 1'b0;
        rst_n        = 1'b0;
        words_sent   = 0;
        idle_cycles  = 0;
        sender_burst = 1'b0;
        drained      = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: stray pairs, the unused action code, a missing
        // presence pulse, all four bit combinations and a restart mid-search.
        send_word(ACT_BIT_PAIR, 1'b1, 1'b1, 1'b0);
        send_word(ACT_UNUSED, 1'b1, 1'b1, 1'b1);
        send_word(ACT_FRESH, 1'b0, 1'b0, 1'b0);
        send_word(ACT_CONTINUE, 1'b1, 1'b0, 1'b0);
        send_word(ACT_BIT_PAIR, 1'b0, 1'b0, 1'b1);
        send_word(ACT_BIT_PAIR, 1'b0, 1'b1, 1'b0);
        send_word(ACT_BIT_PAIR, 1'b1, 1'b0, 1'b0);
        send_word(ACT_BIT_PAIR, 1'b0, 1'b1, 1'b1);
        send_word(ACT_BIT_PAIR, 1'b1, 1'b1, 1'b0);
        send_word(ACT_FRESH, 1'b1, 1'b1, 1'b1);
        send_word(ACT_BIT_PAIR, 1'b0, 1'b1, 1'b0);
        send_word(ACT_CONTINUE, 1'b1, 1'b0, 1'b1);
        send_word(ACT_UNUSED, 1'b0, 1'b0, 1'b0);
        send_word(ACT_BIT_PAIR, 1'b1, 1'b0, 1'b0);

        while (words_sent < WORD_TARGET)
        begin
            enumerate_bus();
            if (!drained && words_sent >= 1100)
            begin
                // Let every outstanding result through before going on.
                @(negedge clk);
                request.valid = 1'b0;
                wait (outstanding == 0);
                drained = 1'b1;
            end
        end

        @(negedge clk);
        request.valid = 1'b0;
        wait (outstanding == 0);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
